>>> hw/rtl/ic2d_pkg.sv
package ic2d_pkg;

   localparam int MAX_RADIUS = 4;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int KDIM  = 2 * MAX_RADIUS + 1;
   localparam int KSIZE = KDIM * KDIM;
   localparam int KI_BITS = $clog2(KSIZE);

   // rows held in the line store: window rows plus the row being filled
   localparam int ROW_BITS  = $clog2(2 * MAX_RADIUS + 2);
   localparam int ROW_SLOTS = 1 << ROW_BITS;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int LINE_DEPTH = ROW_SLOTS * MAX_WIDTH;

   localparam int PROD_BITS = 50;
   localparam int ACC_BITS  = 64;

   typedef enum logic [1:0] {
      REQ_PIXEL = 2'd0,
      REQ_FLUSH = 2'd1,
      REQ_COEF  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TAPS   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic clear;
      logic tap_valid;
   } mac_ctrl_type;

endpackage

>>> hw/rtl/ic2d_ram.sv
module ic2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ic2d_mac.sv
module ic2d_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ic2d_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [31:0]                     pixel,
   input  logic signed [17:0]                     coef,
   output logic signed [ic2d_pkg::ACC_BITS-1:0]   acc,
   output logic                                   busy
);

   logic signed [ic2d_pkg::PROD_BITS-1:0] prod_ff;
   logic                                  prod_valid_ff;
   logic signed [ic2d_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [ic2d_pkg::ACC_BITS-1:0]  acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ic2d_pkg::ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.tap_valid;
      end
      prod_ff <= pixel * coef;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_valid_ff;

endmodule

>>> hw/rtl/image_convolution_2d_top.sv
// A pixel or flush transaction that yields a result starts a window walk (states TAPS, DRAIN,
// FINISH) and its result is registered on the response port; transactions that yield none are
// taken one per cycle while no walk is in progress. Results are paced by the single line store
// read port that fetches one window tap per cycle into one shared multiplier.
// Reset: synchronous, active high; positions clear and registers take their defaults.
// Line store and kernel table contents are undefined until written.
module image_convolution_2d_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_pixel_value,
   input  logic [6:0]         req_coef_index,
   input  logic signed [17:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_out_value,
   output logic [10:0]        rsp_out_x,
   output logic [11:0]        rsp_out_y,
   output logic               rsp_last_of_frame,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CB = ic2d_pkg::COL_BITS;
   localparam int RB = ic2d_pkg::ROW_BITS;
   localparam int KB = ic2d_pkg::KI_BITS;

   ic2d_pkg::state_type state_ff, state_in;

   logic [2:0]  radius_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;

   logic [CB-1:0] in_col_ff, emit_col_ff, wrk_col_ff;
   logic [12:0]   in_row_ff, emit_row_ff, wrk_row_ff;
   logic [23:0]   cur_ff;
   logic          wrk_last_ff;

   logic [3:0]    qq_ff, pp_ff;
   logic [KB-1:0] ki_ff;
   logic          tap_valid_ff;

   logic               rsp_valid_ff;
   logic signed [63:0] rsp_value_ff;
   logic [10:0]        rsp_x_ff;
   logic [11:0]        rsp_y_ff;
   logic               rsp_last_ff;

   logic [2:0]  r_eff;
   logic [11:0] w_eff;
   logic [12:0] h_eff;
   logic [3:0]  kd;
   logic [15:0] lag;

   logic accept, is_stream, produce, last_now, in_wrap, emit_wrap;
   logic cfg_wr, last_tap, tap_ok, load_out;
   logic signed [14:0] ny;
   logic signed [13:0] mx;

   logic [RB+CB-1:0]   line_raddr;
   logic [31:0]        line_rdata;
   logic [17:0]        coef_rdata;
   logic               coef_wr;
   ic2d_pkg::mac_ctrl_type mac_ctrl;
   logic signed [63:0] acc;
   logic               mac_busy;

   always_comb begin
      r_eff = (radius_ff > 3'(ic2d_pkg::MAX_RADIUS)) ? 3'(ic2d_pkg::MAX_RADIUS) : radius_ff;
      if (width_ff == 12'd0) begin
         w_eff = 12'd1;
      end else if (width_ff > 12'(ic2d_pkg::MAX_WIDTH)) begin
         w_eff = 12'(ic2d_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > 13'(ic2d_pkg::MAX_HEIGHT)) begin
         h_eff = 13'(ic2d_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      kd  = {r_eff, 1'b1};
      lag = 16'(r_eff) * 16'(w_eff) + 16'(r_eff);
   end

   assign req_stall = (state_ff != ic2d_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_stream = (req_type == ic2d_pkg::REQ_PIXEL) || (req_type == ic2d_pkg::REQ_FLUSH);
   assign produce   = (cur_ff >= 24'(lag));
   assign last_now  = ({1'b0, emit_col_ff} == w_eff - 12'd1) && (emit_row_ff == h_eff - 13'd1);
   assign in_wrap   = (12'({1'b0, in_col_ff}) + 12'd1) >= w_eff;
   assign emit_wrap = (12'({1'b0, emit_col_ff}) + 12'd1) >= w_eff;
   assign coef_wr   = accept && (req_type == ic2d_pkg::REQ_COEF)
                      && (req_coef_index < 7'(ic2d_pkg::KSIZE));

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         ic2d_pkg::REG_RADIUS: csr_prdata = {29'd0, radius_ff};
         ic2d_pkg::REG_WIDTH:  csr_prdata = {20'd0, width_ff};
         ic2d_pkg::REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // window tap position
   always_comb begin
      ny = $signed({2'b0, wrk_row_ff}) - $signed({12'b0, r_eff}) + $signed({11'b0, qq_ff});
      mx = $signed({3'b0, wrk_col_ff}) - $signed({11'b0, r_eff}) + $signed({10'b0, pp_ff});
      tap_ok = !ny[14] && (ny < $signed({2'b0, h_eff}))
               && !mx[13] && (mx < $signed({2'b0, w_eff}));
      line_raddr = {ny[RB-1:0], mx[CB-1:0]};
      last_tap = (qq_ff == kd - 4'd1) && (pp_ff == kd - 4'd1);
   end

   assign load_out = (state_ff == ic2d_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ic2d_pkg::ST_IDLE: begin
            if (accept && is_stream && produce) state_in = ic2d_pkg::ST_TAPS;
         end
         ic2d_pkg::ST_TAPS: begin
            if (last_tap) state_in = ic2d_pkg::ST_DRAIN;
         end
         ic2d_pkg::ST_DRAIN: begin
            if (!tap_valid_ff && !mac_busy) state_in = ic2d_pkg::ST_FINISH;
         end
         ic2d_pkg::ST_FINISH: begin
            if (load_out) state_in = ic2d_pkg::ST_IDLE;
         end
         default: state_in = ic2d_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ic2d_pkg::ST_IDLE;
         radius_ff    <= 3'd1;
         width_ff     <= 12'(ic2d_pkg::MAX_WIDTH);
         height_ff    <= 13'(ic2d_pkg::MAX_HEIGHT);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         emit_col_ff  <= '0;
         emit_row_ff  <= '0;
         cur_ff       <= '0;
         tap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_valid_ff <= (state_ff == ic2d_pkg::ST_TAPS) && tap_ok;
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               ic2d_pkg::REG_RADIUS: radius_ff <= csr_pwdata[2:0];
               ic2d_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[11:0];
               ic2d_pkg::REG_HEIGHT: height_ff <= csr_pwdata[12:0];
               default: ;
            endcase
            if (csr_paddr[3:2] != ic2d_pkg::REG_NONE) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               emit_col_ff <= '0;
               emit_row_ff <= '0;
               cur_ff      <= '0;
            end
         end else if (accept && is_stream) begin
            if (produce && last_now) begin
               // end of frame: restart all positions
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               emit_col_ff <= '0;
               emit_row_ff <= '0;
               cur_ff      <= '0;
            end else begin
               if (produce) begin
                  if (emit_wrap) begin
                     emit_col_ff <= '0;
                     emit_row_ff <= emit_row_ff + 13'd1;
                  end else begin
                     emit_col_ff <= emit_col_ff + CB'(1);
                  end
               end
               if (in_wrap) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + 13'd1;
               end else begin
                  in_col_ff <= in_col_ff + CB'(1);
               end
               cur_ff <= cur_ff + 24'd1;
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_stream) begin
         wrk_col_ff  <= emit_col_ff;
         wrk_row_ff  <= emit_row_ff;
         wrk_last_ff <= last_now;
      end
      if (state_ff == ic2d_pkg::ST_TAPS) begin
         if (pp_ff == kd - 4'd1) begin
            pp_ff <= '0;
            qq_ff <= qq_ff + 4'd1;
         end else begin
            pp_ff <= pp_ff + 4'd1;
         end
         ki_ff <= ki_ff + KB'(1);
      end else begin
         pp_ff <= '0;
         qq_ff <= '0;
         ki_ff <= '0;
      end
      if (load_out) begin
         rsp_value_ff <= acc;
         rsp_x_ff     <= wrk_col_ff;
         rsp_y_ff     <= wrk_row_ff[11:0];
         rsp_last_ff  <= wrk_last_ff;
      end
   end

   ic2d_ram #(
      .WIDTH (32),
      .DEPTH (ic2d_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && is_stream),
      .wr_addr ({in_row_ff[RB-1:0], in_col_ff}),
      .wr_data ((req_type == ic2d_pkg::REQ_PIXEL) ? req_pixel_value : 32'sd0),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   ic2d_ram #(
      .WIDTH (18),
      .DEPTH (ic2d_pkg::KSIZE)
   ) u_kernel_table (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (req_coef_index[KB-1:0]),
      .wr_data (req_coef_value),
      .rd_addr (ki_ff),
      .rd_data (coef_rdata)
   );

   assign mac_ctrl.clear     = accept && is_stream && produce;
   assign mac_ctrl.tap_valid = tap_valid_ff;

   ic2d_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .pixel ($signed(line_rdata)),
      .coef  ($signed(coef_rdata)),
      .acc   (acc),
      .busy  (mac_busy)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   a_produce_starts_taps: assert property (@(posedge clock) disable iff (reset)
      (accept && is_stream && produce) |=> (state_ff == ic2d_pkg::ST_TAPS))
      else $error("window walk did not start");

   a_no_taps_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ic2d_pkg::ST_IDLE) |=> !mac_busy || $past(tap_valid_ff))
      else $error("multiplier active without a window walk");

   a_finish_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ic2d_pkg::ST_FINISH) |-> (!tap_valid_ff && !mac_busy))
      else $error("result loaded before accumulation finished");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = ic2d_pkg::KSIZE + 10;

   typedef struct {
      logic signed [63:0] value;
      logic [10:0]        x;
      logic [11:0]        y;
      logic               last;
   } conv_result_type;

   class conv_scoreboard;
      conv_result_type    expected_q[$];
      logic signed [17:0] kernel[ic2d_pkg::KSIZE];
      logic signed [31:0] frame_pix[int];
      int unsigned        radius_reg = 1, width_reg = 2048, height_reg = 4096;
      int unsigned        in_col, in_row, emit_col, emit_row;
      int                 errors, checked, frames;

      function int unsigned eff_radius();
         return (radius_reg > ic2d_pkg::MAX_RADIUS) ? ic2d_pkg::MAX_RADIUS : radius_reg;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         return (width_reg > ic2d_pkg::MAX_WIDTH) ? ic2d_pkg::MAX_WIDTH : width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         return (height_reg > ic2d_pkg::MAX_HEIGHT) ? ic2d_pkg::MAX_HEIGHT : height_reg;
      endfunction

      function void restart();
         in_col = 0;
         in_row = 0;
         emit_col = 0;
         emit_row = 0;
         frame_pix.delete();
      endfunction

      function void write_reg(ic2d_pkg::reg_index_type idx, int unsigned val);
         case (idx)
            ic2d_pkg::REG_RADIUS: radius_reg = val & 32'h7;
            ic2d_pkg::REG_WIDTH:  width_reg  = val & 32'hFFF;
            ic2d_pkg::REG_HEIGHT: height_reg = val & 32'h1FFF;
            default: return;
         endcase
         restart();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function int pending();
         return expected_q.size();
      endfunction

      // Update the image and kernel model for one accepted transaction; queue its convolution if it yields one.
      function void note_request(logic [1:0] kind, logic signed [31:0] pix,
                                 logic [6:0] idx, logic signed [17:0] coef);
         int unsigned r, w, h, cur, lag, kd;
         int ny, mx, pos;
         logic signed [63:0] acc;
         conv_result_type res;
         if (kind == ic2d_pkg::REQ_COEF) begin
            if (idx < ic2d_pkg::KSIZE) kernel[idx] = coef;
            return;
         end
         if (kind == ic2d_pkg::REQ_NONE) return;
         r = eff_radius();
         w = eff_width();
         h = eff_height();
         kd = 2 * r + 1;
         cur = in_row * w + in_col;
         lag = r * w + r;
         if (in_row < h) frame_pix[cur] = (kind == ic2d_pkg::REQ_PIXEL) ? pix : 32'sd0;
         if (cur >= lag) begin
            acc = 0;
            for (int q = 0; q < kd; q++) begin
               ny = int'(emit_row) - int'(r) + q;
               if (ny < 0 || ny >= int'(h)) continue;
               for (int p = 0; p < kd; p++) begin
                  mx = int'(emit_col) - int'(r) + p;
                  if (mx < 0 || mx >= int'(w)) continue;
                  pos = ny * int'(w) + mx;
                  if (pos > int'(cur)) continue;
                  acc += 64'(signed'(frame_pix[pos])) * 64'(signed'(kernel[q * kd + p]));
               end
            end
            res.value = acc;
            res.x = emit_col[10:0];
            res.y = emit_row[11:0];
            res.last = (emit_col == w - 1) && (emit_row == h - 1);
            expected_q.push_back(res);
            if (res.last) begin
               frames++;
               restart();
               return;
            end
            if (emit_col + 1 >= w) begin
               emit_col = 0;
               emit_row++;
            end else begin
               emit_col++;
            end
         end
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
      endfunction

      task check_result(logic signed [63:0] value, logic [10:0] x, logic [11:0] y,
                        logic last);
         conv_result_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result x=%0d y=%0d", x, y));
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (value !== e.value)
            report($sformatf("value at (%0d,%0d): got %0d want %0d", e.x, e.y, value, e.value));
         if (x !== e.x) report($sformatf("x: got %0d want %0d", x, e.x));
         if (y !== e.y) report($sformatf("y: got %0d want %0d", y, e.y));
         if (last !== e.last)
            report($sformatf("last at (%0d,%0d): got %0b want %0b", e.x, e.y, last, e.last));
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_type = ic2d_pkg::REQ_FLUSH;
   logic signed [31:0] req_pixel_value = 0;
   logic [6:0]         req_coef_index = 0;
   logic signed [17:0] req_coef_value = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [63:0] rsp_out_value;
   logic [10:0]        rsp_out_x;
   logic [11:0]        rsp_out_y;
   logic               rsp_last_of_frame;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [3:0]         csr_paddr = 0;
   logic [31:0]        csr_pwdata = 0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   conv_scoreboard sb = new();
   int  cycles;
   int  items_sent;
   int  hold_at = -1;
   int  stall_left;
   int  long_hold;
   bit  calm;

   image_convolution_2d_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_value, rsp_out_x, rsp_out_y, rsp_last_of_frame);

   // Result side: short random holds, plus one long hold to back up the pipeline.
   always @(posedge clock) begin
      if (hold_at >= 0 && items_sent >= hold_at) begin
         long_hold = 600;
         hold_at = -1;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
         if (rsp_valid && !rsp_stall && !calm) stall_left = $urandom_range(0, 4);
      end
   end

   task send(logic [1:0] kind, logic signed [31:0] pix, logic [6:0] idx,
             logic signed [17:0] coef);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_pixel_value <= pix;
      req_coef_index <= idx;
      req_coef_value <= coef;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, pix, idx, coef);
      items_sent++;
   endtask

   // Drop valid and wait for all outstanding convolutions plus pipeline slack.
   task settle();
      req_valid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task csr_write(ic2d_pkg::reg_index_type idx, logic [31:0] val);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 4'(4 * idx);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.write_reg(idx, val);
   endtask

   task configure(int unsigned r, int unsigned w, int unsigned h);
      settle();
      csr_write(ic2d_pkg::REG_RADIUS, r);
      csr_write(ic2d_pkg::REG_WIDTH, w);
      csr_write(ic2d_pkg::REG_HEIGHT, h);
   endtask

   function logic signed [31:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   function logic signed [17:0] rand_coef();
      case ($urandom_range(0, 7))
         0: return 18'sh1FFFF;
         1: return 18'sh20000;
         default: return 18'($urandom);
      endcase
   endfunction

   task send_noise();
      case ($urandom_range(0, 2))
         0: send(ic2d_pkg::REQ_NONE, rand_pixel(), 7'($urandom), rand_coef());
         1: send(ic2d_pkg::REQ_COEF, rand_pixel(),
                 7'($urandom_range(ic2d_pkg::KSIZE, 127)), rand_coef());
         default: send(ic2d_pkg::REQ_COEF, rand_pixel(),
                       7'($urandom_range(0, ic2d_pkg::KSIZE - 1)), rand_coef());
      endcase
   endtask

   // Stream one whole region plus a tail of mostly flush transactions that pushes out its last rows.
   task run_frame(bit noisy);
      int unsigned w, h, n;
      w = sb.eff_width();
      h = sb.eff_height();
      n = w * h + sb.eff_radius() * w + sb.eff_radius();
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) send_noise();
         if (i < w * h)
            send(($urandom_range(0, 19) == 0) ? ic2d_pkg::REQ_FLUSH : ic2d_pkg::REQ_PIXEL,
                 rand_pixel(), 0, 0);
         else
            send(($urandom_range(0, 3) == 0) ? ic2d_pkg::REQ_PIXEL : ic2d_pkg::REQ_FLUSH,
                 rand_pixel(), 0, 0);
      end
   endtask

   initial begin
      int unsigned r, w, h;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // full kernel first, so no tap ever reads an unwritten coefficient
      calm = 1;
      for (int i = 0; i < ic2d_pkg::KSIZE; i++)
         send(ic2d_pkg::REQ_COEF, 0, 7'(i),
              (i % 3 == 0) ? 18'sh1FFFF : (i % 3 == 1) ? 18'sh20000 : 18'sh10000);

      calm = 0;
      configure(1, 3, 3);
      send(ic2d_pkg::REQ_PIXEL, 32'sh7FFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh80000000, 0, 0);
      send(ic2d_pkg::REQ_FLUSH, 32'sh7FFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_NONE, 32'sh12345678, 7'h7F, 18'sh1FFFF);
      send(ic2d_pkg::REQ_COEF, 0, 7'h7F, 18'sh00001);
      send(ic2d_pkg::REQ_PIXEL, 32'shFFFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh80000000, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh7FFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh55555555, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'shAAAAAAAA, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh80000000, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh7FFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_FLUSH, 0, 0, 0);
      send(ic2d_pkg::REQ_PIXEL, 32'sh7FFFFFFF, 0, 0);
      send(ic2d_pkg::REQ_FLUSH, 0, 0, 0);
      run_frame(0);

      configure(0, 4095, 8191);
      for (int i = 0; i < 40; i++) send(ic2d_pkg::REQ_PIXEL, rand_pixel(), 0, 0);
      configure(0, 1, 16);
      calm = 1;
      run_frame(0);
      configure(4, 9, 9);
      calm = 0;
      run_frame(1);
      configure(7, 0, 0);
      run_frame(1);

      hold_at = items_sent + 300;
      repeat (12) begin
         r = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         configure(r, w, h);
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 2)) run_frame(1);
      end
      settle();

      $display("run: %0d transactions sent, %0d convolutions checked over %0d frames",
               items_sent, sb.checked, sb.frames);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ic2d_pkg.sv
hw/rtl/ic2d_ram.sv
hw/rtl/ic2d_mac.sv
hw/rtl/image_convolution_2d_top.sv
dv/tb.sv
